// ----- sv/interval_coverage_union_defines.svh -----
// Assertion macros for the files that check their own logic.
`ifndef INTERVAL_COVERAGE_UNION_DEFINES_SVH
`define INTERVAL_COVERAGE_UNION_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define ICU_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define ICU_ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ----- sv/icu_pkg.sv -----
`timescale 1ns / 1ps
package icu_pkg;

  localparam int MaxIntervals = 256;
  localparam int AddrW = $clog2(MaxIntervals);
  localparam int CntW = AddrW + 1;
  localparam int QuoW = 17;
  localparam int DivCntW = $clog2(QuoW);

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdLoad  = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StsOk      = 2'd0,
    StsFull    = 2'd1,
    StsBadSpan = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0]  chrom;
    logic [31:0] start_pos;
    logic [31:0] stop_pos;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
    logic            rem_nz;
  } div_rsp_t;

endpackage

// ----- sv/icu_in_if.sv -----
`timescale 1ns / 1ps
interface icu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  chrom;
  logic [31:0] start_pos;
  logic [31:0] stop_pos;

  modport source (output valid, command, chrom, start_pos, stop_pos, input ready);
  modport sink (input valid, command, chrom, start_pos, stop_pos, output ready);
endinterface

// ----- sv/icu_out_if.sv -----
`timescale 1ns / 1ps
interface icu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] covered_bases;
  logic [31:0] span_length;
  logic [8:0]  hit_count;
  logic [16:0] coverage_q16;
  logic        above_cutoff;

  modport source (output valid, status, covered_bases, span_length, hit_count,
                  coverage_q16, above_cutoff, input ready);
  modport sink (input valid, status, covered_bases, span_length, hit_count,
                coverage_q16, above_cutoff, output ready);
endinterface

// ----- sv/icu_cfg_if.sv -----
`timescale 1ns / 1ps
interface icu_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] cutoff_q16;

  modport source (output valid, cutoff_q16, input ready);
  modport sink (input valid, cutoff_q16, output ready);
endinterface

// ----- sv/icu_div.sv -----
`timescale 1ns / 1ps
// Restoring divider for num*2^16/den with num <= den: one quotient bit a cycle.
module icu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icu_pkg::div_req_t  req_i,
  output icu_pkg::div_rsp_t  rsp_o
);
  import icu_pkg::*;

  logic               busy_q, busy_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [32:0]        rem_q, rem_d;
  logic [31:0]        den_q, den_d;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic               done_q, done_d;
  logic               nz_q, nz_d;
  logic               ge;
  logic [32:0]        rem_sub;

  assign ge = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    nz_d   = nz_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, req_i.num};
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[QuoW-2:0], ge};
      if (cnt_q == DivCntW'(QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        nz_d   = rem_sub != '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        rem_d = {rem_sub[31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    nz_q  <= nz_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quo    = quo_q;
  assign rsp_o.rem_nz = nz_q;
endmodule

// ----- sv/interval_coverage_union.sv -----
`timescale 1ns / 1ps
// Interval coverage union.
// Channels: in_i takes commands (clear, load interval, query span), out_o
// gives one result item for every command, cfg_i writes the coverage cutoff.
// All channels move an item when valid and ready are both high.
// Clear, load, unused commands and empty spans finish in the cycle they are
// accepted; their result is in the output register on the next cycle.
// A query runs passes over the interval table; each pass reads every stored
// interval, fills and drains the read pipeline and then takes the step.
// Each pass either extends the covered run, jumps to the next clip start or,
// when neither is possible, ends the passes and starts the divider. The table
// has a single read port, so every pass reads the stored intervals in turn.
// A restoring divider then forms the Q1.16 coverage; the cutoff flag comes
// from its quotient and remainder, with no multiplier.
// The block takes one item at a time and is ready again when the result
// register is free. A stalled receiver holds the result and the input waits.
// Reset empties the table and clears the cutoff to zero; the table memory
// itself is not cleared, only the fill count.
module interval_coverage_union (
  input  logic clk_i,
  input  logic rst_ni,
  icu_in_if.sink    in_i,
  icu_cfg_if.sink   cfg_i,
  icu_out_if.source out_o
);
  import icu_pkg::*;
  `include "interval_coverage_union_defines.svh"

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StStep = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [16:0]     cutoff_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] addr_q, addr_d;
  logic            rd_vld_q, rd_vld_d;
  logic            clip_vld_q;
  logic            clip_hit_q;
  logic [31:0]     clip_cs_q, clip_ce_q;
  entry_t          mem [MaxIntervals];
  entry_t          rdata_q;
  entry_t          wdata;
  logic            wr_en;

  logic [4:0]      q_chrom_q, q_chrom_d;
  logic [31:0]     q_start_q, q_start_d;
  logic [31:0]     q_stop_q, q_stop_d;
  logic [31:0]     cur_q, cur_d;
  logic [31:0]     maxext_q, maxext_d;
  logic [31:0]     minst_q, minst_d;
  logic            found_q, found_d;
  logic [31:0]     cov_q, cov_d;
  logic [CntW-1:0] hits_q, hits_d;
  logic            first_q, first_d;

  logic            out_vld_q, out_vld_d;
  logic [1:0]      o_status_q, o_status_d;
  logic [31:0]     o_cov_q, o_cov_d;
  logic [31:0]     o_len_q, o_len_d;
  logic [8:0]      o_hits_q, o_hits_d;
  logic [16:0]     o_q16_q, o_q16_d;
  logic            o_flag_q, o_flag_d;

  logic            out_free;
  logic            in_acc;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  logic [31:0]     c_cs, c_ce;
  logic            c_hit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
    end else if (cfg_i.valid) begin
      cutoff_q <= cfg_i.cutoff_q16;
    end
  end

  assign out_free   = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // Table memory: one write port for loads, one registered read port for scans.
  assign wdata = '{chrom: in_i.chrom, start_pos: in_i.start_pos, stop_pos: in_i.stop_pos};
  assign wr_en = in_acc && (in_i.command == CmdLoad) && (count_q != CntW'(MaxIntervals));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AddrW-1:0]] <= wdata;
    end
    if (rd_vld_d) begin
      rdata_q <= mem[addr_q[AddrW-1:0]];
    end
  end

  // First scan stage: clip the stored interval against the query span.
  assign c_cs  = (rdata_q.start_pos > q_start_q) ? rdata_q.start_pos : q_start_q;
  assign c_ce  = (rdata_q.stop_pos < q_stop_q) ? rdata_q.stop_pos : q_stop_q;
  assign c_hit = (rdata_q.chrom == q_chrom_q) && (c_ce > c_cs);

  always_ff @(posedge clk_i) begin
    clip_cs_q  <= c_cs;
    clip_ce_q  <= c_ce;
    clip_hit_q <= c_hit;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    addr_d     = addr_q;
    rd_vld_d   = 1'b0;
    q_chrom_d  = q_chrom_q;
    q_start_d  = q_start_q;
    q_stop_d   = q_stop_q;
    cur_d      = cur_q;
    maxext_d   = maxext_q;
    minst_d    = minst_q;
    found_d    = found_q;
    cov_d      = cov_q;
    hits_d     = hits_q;
    first_d    = first_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    o_status_d = o_status_q;
    o_cov_d    = o_cov_q;
    o_len_d    = o_len_q;
    o_hits_d   = o_hits_q;
    o_q16_d    = o_q16_q;
    o_flag_d   = o_flag_q;
    div_req.start = 1'b0;
    div_req.num   = cov_q;
    div_req.den   = q_stop_q - q_start_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          o_status_d = StsOk;
          o_cov_d    = '0;
          o_len_d    = '0;
          o_hits_d   = '0;
          o_q16_d    = '0;
          o_flag_d   = 1'b0;
          case (in_i.command)
            CmdClear: begin
              count_d   = '0;
              out_vld_d = 1'b1;
            end
            CmdLoad: begin
              if (count_q == CntW'(MaxIntervals)) begin
                o_status_d = StsFull;
              end else begin
                count_d = count_q + 1'b1;
              end
              out_vld_d = 1'b1;
            end
            CmdQuery: begin
              if (in_i.stop_pos <= in_i.start_pos) begin
                o_status_d = StsBadSpan;
                out_vld_d  = 1'b1;
              end else begin
                q_chrom_d = in_i.chrom;
                q_start_d = in_i.start_pos;
                q_stop_d  = in_i.stop_pos;
                cur_d     = in_i.start_pos;
                maxext_d  = in_i.start_pos;
                found_d   = 1'b0;
                cov_d     = '0;
                hits_d    = '0;
                first_d   = 1'b1;
                addr_d    = '0;
                state_d   = StScan;
              end
            end
            default: begin
              out_vld_d = 1'b1;
            end
          endcase
        end
      end
      StScan: begin
        if (addr_q < count_q) begin
          rd_vld_d = 1'b1;
          addr_d   = addr_q + 1'b1;
        end
        // Second scan stage: extend the run from cur or track the next start.
        if (clip_vld_q && clip_hit_q) begin
          if (first_q) begin
            hits_d = hits_q + 1'b1;
          end
          if (clip_cs_q <= cur_q) begin
            if (clip_ce_q > maxext_q) begin
              maxext_d = clip_ce_q;
            end
          end else if (!found_q || (clip_cs_q < minst_q)) begin
            minst_d = clip_cs_q;
            found_d = 1'b1;
          end
        end
        if ((addr_q == count_q) && !rd_vld_q && !clip_vld_q) begin
          state_d = StStep;
        end
      end
      StStep: begin
        first_d = 1'b0;
        addr_d  = '0;
        found_d = 1'b0;
        if (maxext_q > cur_q) begin
          cov_d    = cov_q + (maxext_q - cur_q);
          cur_d    = maxext_q;
          maxext_d = maxext_q;
          state_d  = StScan;
        end else if (found_q) begin
          cur_d    = minst_q;
          maxext_d = minst_q;
          state_d  = StScan;
        end else begin
          div_req.start = 1'b1;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          o_q16_d  = div_rsp.quo;
          // cov*2^16 = q*len + r with r < len, so the product compare reduces
          // to the quotient against the cutoff, with the remainder as tiebreak.
          o_flag_d = ({1'b0, div_rsp.quo} > {1'b0, cutoff_q}) ||
                     ((div_rsp.quo == cutoff_q) && div_rsp.rem_nz);
          state_d  = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          o_status_d = StsOk;
          o_cov_d    = cov_q;
          o_len_d    = q_stop_q - q_start_q;
          o_hits_d   = 9'(hits_q);
          out_vld_d  = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  icu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      clip_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      first_q    <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      addr_q     <= addr_d;
      rd_vld_q   <= rd_vld_d;
      clip_vld_q <= rd_vld_q;
      out_vld_q  <= out_vld_d;
      first_q    <= first_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_chrom_q  <= q_chrom_d;
    q_start_q  <= q_start_d;
    q_stop_q   <= q_stop_d;
    cur_q      <= cur_d;
    maxext_q   <= maxext_d;
    minst_q    <= minst_d;
    cov_q      <= cov_d;
    hits_q     <= hits_d;
    o_status_q <= o_status_d;
    o_cov_q    <= o_cov_d;
    o_len_q    <= o_len_d;
    o_hits_q   <= o_hits_d;
    o_q16_q    <= o_q16_d;
    o_flag_q   <= o_flag_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = o_status_q;
  assign out_o.covered_bases = o_cov_q;
  assign out_o.span_length   = o_len_q;
  assign out_o.hit_count     = o_hits_q;
  assign out_o.coverage_q16  = o_q16_q;
  assign out_o.above_cutoff  = o_flag_q;

  `ICU_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_rsp.done |-> (state_q == StDiv))
  `ICU_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MaxIntervals))
  `ICU_ASSERT(a_run_in_span, clk_i, rst_ni,
              (state_q == StScan) |-> ((cur_q >= q_start_q) && (cur_q <= q_stop_q)))
  `ICU_ASSERT_NEVER(a_cov_over_span, clk_i, rst_ni,
                    out_vld_q && (o_cov_q > o_len_q))
endmodule

// ----- tb/sv/tb_interval_coverage_union.sv -----
`timescale 1ns / 1ps
module tb_interval_coverage_union;
  import icu_pkg::*;

  localparam logic [1:0] CmdSpare = 2'd3;
  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned RandItems = 720;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] covered;
    logic [31:0] span;
    logic [8:0]  hits;
    logic [16:0] coverage;
    logic        above;
  } result_t;

  class coverage_scoreboard;
    result_t     expected_q[$];
    entry_t      intervals[MaxIntervals];
    int unsigned fill;
    logic [16:0] cutoff;
    int unsigned errors;
    int unsigned queries;
    int unsigned max_hits;
    int unsigned full_hits;

    function void reset_state();
      fill = 0;
      cutoff = '0;
      expected_q.delete();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    function result_t predict_coverage(logic [1:0] cmd, logic [4:0] chrom,
                                       logic [31:0] s, logic [31:0] e);
      result_t     r;
      logic [31:0] clip_lo[$];
      logic [31:0] clip_hi[$];
      logic [31:0] lo, hi, run_lo, run_hi, total;
      logic [63:0] scaled, quo, limit;
      int          k;
      r = '0;
      case (cmd)
        CmdClear: fill = 0;
        CmdLoad: begin
          if (fill < MaxIntervals) begin
            intervals[fill] = '{chrom: chrom, start_pos: s, stop_pos: e};
            fill++;
          end else begin
            r.status = StsFull;
            full_hits++;
          end
        end
        CmdQuery: begin
          if (e <= s) begin
            r.status = StsBadSpan;
          end else begin
            queries++;
            for (int i = 0; i < fill; i++) begin
              if (intervals[i].chrom == chrom) begin
                lo = intervals[i].start_pos > s ? intervals[i].start_pos : s;
                hi = intervals[i].stop_pos < e ? intervals[i].stop_pos : e;
                if (hi > lo) begin
                  // Keep the clips ordered by start, later equal starts last.
                  k = clip_lo.size();
                  while (k > 0 && clip_lo[k-1] > lo) k--;
                  clip_lo.insert(k, lo);
                  clip_hi.insert(k, hi);
                end
              end
            end
            total = '0;
            if (clip_lo.size() > 0) begin
              run_lo = clip_lo[0];
              run_hi = clip_hi[0];
              for (int i = 1; i < clip_lo.size(); i++) begin
                if (clip_lo[i] <= run_hi) begin
                  if (clip_hi[i] > run_hi) run_hi = clip_hi[i];
                end else begin
                  total += run_hi - run_lo;
                  run_lo = clip_lo[i];
                  run_hi = clip_hi[i];
                end
              end
              total += run_hi - run_lo;
            end
            scaled = {total, 16'h0};
            quo = scaled / {32'h0, e - s};
            limit = {47'h0, cutoff} * {32'h0, e - s};
            r.covered = total;
            r.span = e - s;
            r.hits = clip_lo.size() > 511 ? 9'd511 : 9'(clip_lo.size());
            r.coverage = quo[16:0];
            r.above = scaled > limit;
            if (clip_lo.size() > max_hits) max_hits = clip_lo.size();
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(logic [1:0] cmd, logic [4:0] chrom,
                             logic [31:0] s, logic [31:0] e);
      expected_q.insert(expected_q.size(), predict_coverage(cmd, chrom, s, e));
    endfunction

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.covered !== want.covered)
          report($sformatf("covered %0d, expected %0d", got.covered, want.covered));
        if (got.span !== want.span)
          report($sformatf("span %0d, expected %0d", got.span, want.span));
        if (got.hits !== want.hits)
          report($sformatf("hits %0d, expected %0d", got.hits, want.hits));
        if (got.coverage !== want.coverage)
          report($sformatf("coverage %0d, expected %0d", got.coverage, want.coverage));
        if (got.above !== want.above)
          report($sformatf("above %0d, expected %0d", got.above, want.above));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic calm = 1'b0;
  int unsigned cycles = 0;
  coverage_scoreboard sb = new();

  icu_in_if  in_bus();
  icu_cfg_if cfg_bus();
  icu_out_if out_bus();

  interval_coverage_union u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .cfg_i (cfg_bus),
    .out_o (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.command = CmdClear;
    in_bus.chrom = '0;
    in_bus.start_pos = '0;
    in_bus.stop_pos = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.cutoff_q16 = '0;
    out_bus.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_bus.ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      sb.note_input(in_bus.command, in_bus.chrom, in_bus.start_pos, in_bus.stop_pos);
    if (rst_ni && cfg_bus.valid && cfg_bus.ready) sb.cutoff = cfg_bus.cutoff_q16;
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_result('{status: out_bus.status, covered: out_bus.covered_bases,
                        span: out_bus.span_length, hits: out_bus.hit_count,
                        coverage: out_bus.coverage_q16, above: out_bus.above_cutoff});
  end

  task send_item(logic [1:0] cmd, logic [4:0] chrom, logic [31:0] s, logic [31:0] e);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.chrom <= chrom;
    in_bus.start_pos <= s;
    in_bus.stop_pos <= e;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Drops valid and holds off until every result is back and the block is idle.
  task drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task write_cutoff(logic [16:0] value);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.cutoff_q16 <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function logic [16:0] pick_cutoff();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      3: return 17'd32768;
      4: return 17'd65535;
      default: return 17'($urandom);
    endcase
  endfunction

  task random_load(logic [31:0] base);
    logic [31:0] s;
    if ($urandom_range(0, 9) == 0) begin
      send_item(CmdLoad, 5'($urandom), $urandom, $urandom);
    end else begin
      s = base + $urandom_range(0, 300);
      send_item(CmdLoad, 5'($urandom_range(0, 2)), s, s + $urandom_range(0, 120) - 10);
    end
  endtask

  task random_query(logic [31:0] base);
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0: send_item(CmdQuery, 5'($urandom), $urandom, $urandom);
      1: begin
        s = $urandom;
        send_item(CmdQuery, 5'($urandom_range(0, 2)), s, s - $urandom_range(0, 3));
      end
      default: begin
        s = base + $urandom_range(0, 250);
        send_item(CmdQuery, 5'($urandom_range(0, 2)), s, s + $urandom_range(1, 300));
      end
    endcase
  endtask

  int unsigned sent;
  int unsigned loads;
  logic [31:0] base;

  initial begin
    sb.reset_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, whole-range interval, inverted entries and spans,
    // touching clips, the unused command and a clear.
    send_item(CmdQuery, 5'd0, 32'd0, 32'd100);
    send_item(CmdLoad, 5'd31, 32'h0, 32'hFFFF_FFFF);
    send_item(CmdLoad, 5'd31, 32'd100, 32'd50);
    send_item(CmdQuery, 5'd31, 32'h0, 32'hFFFF_FFFF);
    send_item(CmdQuery, 5'd31, 32'hFFFF_FFFF, 32'h0);
    send_item(CmdQuery, 5'd31, 32'd77, 32'd77);
    send_item(CmdSpare, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CmdLoad, 5'd1, 32'd10, 32'd20);
    send_item(CmdLoad, 5'd1, 32'd20, 32'd30);
    send_item(CmdLoad, 5'd1, 32'd40, 32'd50);
    send_item(CmdLoad, 5'd1, 32'd5, 32'd12);
    send_item(CmdQuery, 5'd1, 32'd0, 32'd100);
    send_item(CmdQuery, 5'd1, 32'd15, 32'd45);
    send_item(CmdQuery, 5'd1, 32'd30, 32'd40);
    send_item(CmdQuery, 5'd31, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(CmdClear, 5'd0, 32'd0, 32'd0);
    send_item(CmdQuery, 5'd1, 32'd0, 32'd100);

    // Fill the table to the top, overflow it and query the full table.
    write_cutoff(17'd65536);
    for (int i = 0; i < MaxIntervals; i++)
      send_item(CmdLoad, 5'(i), 32'(i * 40), 32'(i * 40 + 2000));
    send_item(CmdLoad, 5'd3, 32'd0, 32'd10);
    send_item(CmdQuery, 5'd5, 32'd0, 32'd20000);
    send_item(CmdQuery, 5'd31, 32'd1000, 32'd1500);
    send_item(CmdQuery, 5'd0, 32'h0, 32'hFFFF_FFFF);
    send_item(CmdClear, 5'd0, 32'd0, 32'd0);

    write_cutoff(17'd0);
    sent = 0;
    while (sent < RandItems) begin
      if (sent % 150 == 149) write_cutoff(pick_cutoff());
      calm = (sent >= 400 && sent < 520);
      base = $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 5000));
      if (sb.fill > 30 || $urandom_range(0, 1) == 0) begin
        send_item(CmdClear, 5'($urandom), $urandom, $urandom);
        sent++;
      end
      loads = $urandom_range(0, 8);
      for (int i = 0; i < loads; i++) random_load(base);
      sent += loads;
      for (int i = $urandom_range(2, 6); i > 0; i--) random_query(base);
      sent += 4;
      if ($urandom_range(0, 19) == 0) begin
        send_item(CmdSpare, 5'($urandom), $urandom, $urandom);
        sent++;
      end
    end
    calm = 1'b0;
    drain();

    $display("Covered %0d positive-span queries, up to %0d hits in one, %0d loads refused",
             sb.queries, sb.max_hits, sb.full_hits);
    $display("with cutoffs from zero to past one and random stalls on both sides.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
